>>> hdl/tcsd_pkg.sv
// shared types and constants for the tap run cold start detector
`default_nettype none

package tcsd_pkg;

	localparam int TIME_W   = 32;
	localparam int SEC_W    = 16;
	localparam int WDAY_W   = 3;
	localparam int MINUTE_W = 11;
	localparam int BUCKET_W = 9;
	localparam int WEIGHT_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLD_GAP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOT_WINDOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RECIRC   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GENUINE  = 3'd4;

	// register reset values
	localparam logic [SEC_W-1:0] COLD_GAP_RST    = 16'd300;
	localparam logic [SEC_W-1:0] HOT_WINDOW_RST  = 16'd900;
	localparam logic [SEC_W-1:0] MIN_RECIRC_RST  = 16'd30;
	localparam logic [SEC_W-1:0] MIN_GENUINE_RST = 16'd30;

	// minute / 5 as (minute * 3277) >> 14, exact over the 11 bit range
	localparam int BKT_PROD_W = 23;
	localparam int BKT_SHIFT  = 14;
	localparam logic [BKT_PROD_W-1:0] BKT_RECIP = 23'd3277;
	localparam logic [BUCKET_W-1:0] BUCKET_MAX = 9'd287;

	// weights in halves
	localparam logic [WEIGHT_W-1:0] WEIGHT_NONE = 2'd0;
	localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 2'd1;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 2'd2;

	typedef struct packed {
		logic             enable;
		logic [SEC_W-1:0] idle_gap_sec;
		logic [SEC_W-1:0] hot_window_sec;
		logic [SEC_W-1:0] min_recirc_duration_sec;
		logic [SEC_W-1:0] min_genuine_duration_sec;
	} cfg_t;

	typedef struct packed {
		logic                consumption_on;
		logic                recirc_on;
		logic [TIME_W-1:0]   now_sec;
		logic [WDAY_W-1:0]   weekday;
		logic [MINUTE_W-1:0] minute_of_day;
	} samp_t;

	typedef struct packed {
		logic                valid;
		logic [WDAY_W-1:0]   event_weekday;
		logic [BUCKET_W-1:0] event_bucket;
		logic [WEIGHT_W-1:0] weight_halves;
		logic                pipes_were_hot;
	} evt_t;

endpackage

`default_nettype wire

>>> hdl/tap_run_cold_start_detector_unit.sv
// top level of the tap run cold start detector
// Takes one sensor sample word per clock and gives at most one cold start
// event word per sample, registered from the sample in the input
// register: the whole update is one pass of compares and subtractions
// between the input register and the state and result registers, so the
// sustained rate is one sample per cycle while the result side keeps up.
// A stalled result register holds the next sample in the input register.
// Configuration writes are always ready and take effect at the next sample.
`default_nettype none

module tap_run_cold_start_detector_unit
	import tcsd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// sample channel
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic                  consumption_on,
	input  wire logic                  recirc_on,
	input  wire logic [TIME_W-1:0]     now_sec,
	input  wire logic [WDAY_W-1:0]     weekday,
	input  wire logic [MINUTE_W-1:0]   minute_of_day,
	// event channel
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [WDAY_W-1:0]     event_weekday,
	output      logic [BUCKET_W-1:0]   event_bucket,
	output      logic [WEIGHT_W-1:0]   weight_halves,
	output      logic                  pipes_were_hot,
	// configuration channel
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	samp_t samp_s1;
	logic  v_s1;
	evt_t  evt;
	evt_t  res_q;
	logic  fire;
	logic  in_take;

	assign cfg_ready = 1'b1;

	tcsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sample moves on when the result register is free or draining
	assign fire     = v_s1 && (!res_q.valid || !out_stall);
	assign in_stall = v_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_take)
			v_s1 <= 1'b1;
		else if (fire)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			samp_s1.consumption_on <= consumption_on;
			samp_s1.recirc_on      <= recirc_on;
			samp_s1.now_sec        <= now_sec;
			samp_s1.weekday        <= weekday;
			samp_s1.minute_of_day  <= minute_of_day;
		end
	end

	tcsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.samp   (samp_s1),
		.cfg    (cfg),
		.evt    (evt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			if (fire)
				res_q.valid <= evt.valid;
			else if (!out_stall)
				res_q.valid <= 1'b0;
			if (fire && evt.valid) begin
				res_q.event_weekday  <= evt.event_weekday;
				res_q.event_bucket   <= evt.event_bucket;
				res_q.weight_halves  <= evt.weight_halves;
				res_q.pipes_were_hot <= evt.pipes_were_hot;
			end
		end
	end

	assign out_valid      = res_q.valid;
	assign event_weekday  = res_q.event_weekday;
	assign event_bucket   = res_q.event_bucket;
	assign weight_halves  = res_q.weight_halves;
	assign pipes_were_hot = res_q.pipes_were_hot;

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && res_q.valid && out_stall)
		else $error("input stalled without a blocked result");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid && out_stall |-> !fire)
		else $error("pending result overwritten");
	a_weight_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weight_halves == WEIGHT_HALF || weight_halves == WEIGHT_FULL)
		else $error("event with zero weight");
`endif

endmodule

`default_nettype wire

>>> hdl/tcsd_cfg.sv
// configuration register file
`default_nettype none

module tcsd_cfg
	import tcsd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output      cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, out of range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable                   <= 1'b1;
			cfg_q.idle_gap_sec             <= COLD_GAP_RST;
			cfg_q.hot_window_sec           <= HOT_WINDOW_RST;
			cfg_q.min_recirc_duration_sec  <= MIN_RECIRC_RST;
			cfg_q.min_genuine_duration_sec <= MIN_GENUINE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:      cfg_q.enable                   <= cfg_data[0];
				REG_COLD_GAP:    cfg_q.idle_gap_sec             <= cfg_data;
				REG_HOT_WINDOW:  cfg_q.hot_window_sec           <= cfg_data;
				REG_MIN_RECIRC:  cfg_q.min_recirc_duration_sec  <= cfg_data;
				REG_MIN_GENUINE: cfg_q.min_genuine_duration_sec <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/tcsd_core.sv
// run tracking state and per-sample update logic
`default_nettype none

module tcsd_core
	import tcsd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire samp_t samp,
	input  wire cfg_t  cfg,
	output      evt_t  evt
);

	logic                in_run_q;
	logic [TIME_W-1:0]   last_active_q;
	logic [TIME_W-1:0]   run_start_q;
	logic [TIME_W-1:0]   run_dur_q;
	logic [WDAY_W-1:0]   run_wday_q;
	logic [BUCKET_W-1:0] run_bucket_q;
	logic                run_hot_q;
	logic [TIME_W-1:0]   last_recirc_q;

	logic                cold;
	logic                recent;
	logic                cold_start;
	logic [TIME_W-1:0]   start_eff;
	logic [TIME_W-1:0]   dur_nx;
	logic [BKT_PROD_W-1:0] bkt_prod;
	logic [BUCKET_W-1:0] bkt_quot;
	logic [BUCKET_W-1:0] bucket;
	logic [WEIGHT_W-1:0] weight;
	logic                upd;

	assign upd = fire && cfg.enable;

	// idle gap test, never seen counts as cold
	always_comb begin
		if (last_active_q == '0)
			cold = 1'b1;
		else if (samp.now_sec < last_active_q)
			cold = 1'b0;
		else
			cold = (samp.now_sec - last_active_q) >= {16'd0, cfg.idle_gap_sec};
	end

	// pipes hot if pump on now or within the hot window
	always_comb begin
		if (samp.recirc_on)
			recent = 1'b1;
		else if (last_recirc_q == '0)
			recent = 1'b0;
		else if (samp.now_sec < last_recirc_q)
			recent = 1'b1;
		else
			recent = (samp.now_sec - last_recirc_q) < {16'd0, cfg.hot_window_sec};
	end

	// five minute bucket, saturated
	assign bkt_prod = BKT_PROD_W'(samp.minute_of_day) * BKT_RECIP;
	assign bkt_quot = bkt_prod[BKT_SHIFT +: BUCKET_W];
	assign bucket   = (bkt_quot > BUCKET_MAX) ? BUCKET_MAX : bkt_quot;

	assign cold_start = samp.consumption_on && !in_run_q && cold;
	assign start_eff  = cold_start ? samp.now_sec : run_start_q;
	assign dur_nx     = (samp.now_sec >= start_eff) ? (samp.now_sec - start_eff) : '0;

	// weigh the finished run
	always_comb begin
		if (run_hot_q)
			weight = (run_dur_q >= {16'd0, cfg.min_recirc_duration_sec}) ?
				WEIGHT_FULL : WEIGHT_NONE;
		else
			weight = (run_dur_q >= {16'd0, cfg.min_genuine_duration_sec}) ?
				WEIGHT_FULL : WEIGHT_HALF;
	end

	// event on the falling consumption edge
	always_comb begin
		evt.valid          = upd && !samp.consumption_on && in_run_q && (weight != WEIGHT_NONE);
		evt.event_weekday  = run_wday_q;
		evt.event_bucket   = run_bucket_q;
		evt.weight_halves  = weight;
		evt.pipes_were_hot = run_hot_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q      <= 1'b0;
			last_active_q <= '0;
			last_recirc_q <= '0;
			run_start_q   <= '0;
			run_dur_q     <= '0;
			run_hot_q     <= 1'b0;
			run_wday_q    <= '0;
			run_bucket_q  <= '0;
		end else if (upd) begin
			in_run_q <= samp.consumption_on;
			if (samp.consumption_on) begin
				last_active_q <= samp.now_sec;
				run_dur_q     <= dur_nx;
			end
			if (cold_start) begin
				run_start_q  <= samp.now_sec;
				run_hot_q    <= recent;
				run_wday_q   <= samp.weekday;
				run_bucket_q <= bucket;
			end
			if (samp.recirc_on)
				last_recirc_q <= samp.now_sec;
		end
	end

`ifndef SYNTH
	a_evt_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |=> !in_run_q)
		else $error("run still open after event");
	a_cons_opens_run: assert property (@(posedge clk) disable iff (!arst_n)
		upd && samp.consumption_on |=> in_run_q)
		else $error("consumption did not open run");
	a_hot_full: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && run_hot_q |-> evt.weight_halves == WEIGHT_FULL)
		else $error("hot run event with partial weight");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(in_run_q) && $stable(last_active_q) && $stable(last_recirc_q))
		else $error("state changed without sample");
`endif

endmodule

`default_nettype wire
